@@ design/bpa_pkg.sv @@
// ---------------------------------------------------------------------------
// bpa_pkg - shared types and constants of the buddy page allocator
// Table entry layout, command and status bundles, FSM states, reset values.
// ---------------------------------------------------------------------------
package bpa_pkg;

	localparam int PAGES   = 1024;
	localparam int ORDERS  = 10;
	localparam int PAGE_W  = 10;
	localparam int IDX_W   = PAGE_W + 1;
	localparam int ORD_W   = 4;
	localparam int CNT_W   = $clog2(PAGES + 1);
	localparam int ENT_W   = 6;
	localparam int TOP_SZ  = 1 << (ORDERS - 1);
	localparam int FULL    = PAGES - (PAGES % TOP_SZ);

	localparam logic [ENT_W-1:0] ENT_HEAD = 6'h20;
	localparam logic [ENT_W-1:0] ENT_BUSY = 6'h10;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFREE  = 2'd1,
		STAT_BADFREE = 2'd2
	} stat_code_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_RD_IDX,
		CMD_SCAN_NEXT,
		CMD_TAKE,
		CMD_SPLIT,
		CMD_MARK_BUSY,
		CMD_RD_PAGE,
		CMD_CLR_PAGE,
		CMD_RD_BUDDY,
		CMD_MERGE,
		CMD_PUT_FREE
	} cmd_op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SPLIT,
		S_FREE_RD,
		S_FREE_CHK,
		S_MERGE_TRY,
		S_MERGE_CHK,
		S_RESP
	} state_t;

	typedef struct packed {
		cmd_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic              alloc_ok;
		logic              req_ok;
		logic              hit_free;
		logic              hit_busy;
		logic              split_more;
		logic              merge_try;
		logic              clr_done;
		logic [PAGE_W-1:0] page;
	} dp_stat_t;

	typedef struct packed {
		logic       valid;
		stat_code_t code;
		logic       use_page;
	} resp_t;

	// table contents after reset
	function automatic logic [ENT_W-1:0] reset_entry(input logic [PAGE_W-1:0] idx);
		logic [ENT_W-1:0] e;
		if ({1'b0, idx} < IDX_W'(FULL)) begin
			if ((idx & PAGE_W'(TOP_SZ - 1)) == '0)
				e = ENT_HEAD | ENT_W'(ORDERS - 1);
			else
				e = '0;
		end else begin
			e = ENT_HEAD;
		end
		return e;
	endfunction

	function automatic logic [CNT_W-1:0] reset_count(input int o);
		logic [CNT_W-1:0] c;
		if (o == 0)
			c = CNT_W'(PAGES - FULL);
		else if (o == ORDERS - 1)
			c = CNT_W'(FULL / TOP_SZ);
		else
			c = '0;
		return c;
	endfunction

endpackage

@@ design/bpa_dp.sv @@
// ---------------------------------------------------------------------------
// bpa_dp - allocator datapath
// Block table memory, per-order free counters and the walk registers.
// ---------------------------------------------------------------------------
module bpa_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpa_pkg::dp_cmd_t          cmd,
	input  logic                      opcode,
	input  logic [bpa_pkg::ORD_W-1:0] block_order,
	input  logic [bpa_pkg::PAGE_W-1:0] page_index,
	output bpa_pkg::dp_stat_t         stat
);

	logic [bpa_pkg::ENT_W-1:0]  mem [bpa_pkg::PAGES];
	logic [bpa_pkg::ENT_W-1:0]  rdata_s1;
	logic [bpa_pkg::CNT_W-1:0]  cnt_q [bpa_pkg::ORDERS];
	logic [bpa_pkg::IDX_W-1:0]  clr_q;
	logic [bpa_pkg::IDX_W-1:0]  idx_q;
	logic [bpa_pkg::ORD_W-1:0]  ord_q;
	logic [bpa_pkg::ORD_W-1:0]  req_q;
	logic [bpa_pkg::PAGE_W-1:0] page_q;

	logic [bpa_pkg::ORD_W-1:0]  found_ord;
	logic                       found;
	logic [bpa_pkg::ORD_W-1:0]  ord_dn;
	logic [bpa_pkg::PAGE_W-1:0] bit_o;
	logic [bpa_pkg::PAGE_W-1:0] buddy;
	logic [bpa_pkg::PAGE_W-1:0] addr;
	logic [bpa_pkg::ENT_W-1:0]  wdata;
	logic                       we;

	// smallest order at or above the request with a free block
	always_comb begin
		found     = 1'b0;
		found_ord = '0;
		for (int o = bpa_pkg::ORDERS - 1; o >= 0; o--) begin
			if (({1'b0, bpa_pkg::ORD_W'(o)} >= {1'b0, block_order}) && (cnt_q[o] != '0)) begin
				found     = 1'b1;
				found_ord = bpa_pkg::ORD_W'(o);
			end
		end
	end

	assign ord_dn = ord_q - 1'b1;
	assign bit_o  = bpa_pkg::PAGE_W'(1) << ord_q;
	assign buddy  = page_q ^ bit_o;

	always_comb begin
		addr  = page_q;
		wdata = '0;
		we    = 1'b0;
		case (cmd.op)
			bpa_pkg::CMD_CLEAR: begin
				addr  = clr_q[bpa_pkg::PAGE_W-1:0];
				wdata = bpa_pkg::reset_entry(clr_q[bpa_pkg::PAGE_W-1:0]);
				we    = 1'b1;
			end
			bpa_pkg::CMD_RD_IDX: addr = idx_q[bpa_pkg::PAGE_W-1:0];
			bpa_pkg::CMD_SPLIT: begin
				wdata = bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(ord_dn);
				we    = 1'b1;
			end
			bpa_pkg::CMD_MARK_BUSY: begin
				wdata = bpa_pkg::ENT_HEAD | bpa_pkg::ENT_BUSY | bpa_pkg::ENT_W'(req_q);
				we    = 1'b1;
			end
			bpa_pkg::CMD_CLR_PAGE: we = 1'b1;
			bpa_pkg::CMD_RD_BUDDY: addr = buddy;
			bpa_pkg::CMD_MERGE: begin
				addr = buddy;
				we   = 1'b1;
			end
			bpa_pkg::CMD_PUT_FREE: begin
				wdata = bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(ord_q);
				we    = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int o = 0; o < bpa_pkg::ORDERS; o++)
				cnt_q[o] <= bpa_pkg::reset_count(o);
		end else begin
			case (cmd.op)
				bpa_pkg::CMD_CLEAR:    clr_q <= clr_q + 1'b1;
				bpa_pkg::CMD_TAKE:     cnt_q[ord_q] <= cnt_q[ord_q] - 1'b1;
				bpa_pkg::CMD_SPLIT:    cnt_q[ord_dn] <= cnt_q[ord_dn] + 1'b1;
				bpa_pkg::CMD_MERGE:    cnt_q[ord_q] <= cnt_q[ord_q] - 1'b1;
				bpa_pkg::CMD_PUT_FREE: cnt_q[ord_q] <= cnt_q[ord_q] + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bpa_pkg::CMD_LOAD: begin
				req_q  <= block_order;
				ord_q  <= (opcode == bpa_pkg::OP_FREE) ? block_order : found_ord;
				page_q <= page_index;
				idx_q  <= '0;
			end
			bpa_pkg::CMD_SCAN_NEXT: idx_q <= idx_q + {1'b0, bit_o};
			bpa_pkg::CMD_TAKE:      page_q <= idx_q[bpa_pkg::PAGE_W-1:0];
			bpa_pkg::CMD_SPLIT: begin
				page_q <= page_q + (bpa_pkg::PAGE_W'(1) << ord_dn);
				ord_q  <= ord_dn;
			end
			bpa_pkg::CMD_MERGE: begin
				page_q <= page_q & ~bit_o;
				ord_q  <= ord_q + 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.alloc_ok   = found;
		stat.req_ok     = ({1'b0, block_order} < (bpa_pkg::ORD_W + 1)'(bpa_pkg::ORDERS))
			&& ({1'b0, page_index} < bpa_pkg::IDX_W'(bpa_pkg::PAGES));
		stat.hit_free   = rdata_s1 == (bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(ord_q));
		stat.hit_busy   = rdata_s1 ==
			(bpa_pkg::ENT_HEAD | bpa_pkg::ENT_BUSY | bpa_pkg::ENT_W'(ord_q));
		stat.split_more = ord_q != req_q;
		stat.merge_try  = ({1'b0, ord_q} + 1'b1 < (bpa_pkg::ORD_W + 1)'(bpa_pkg::ORDERS))
			&& ({1'b0, buddy} < bpa_pkg::IDX_W'(bpa_pkg::PAGES));
		stat.clr_done   = clr_q == bpa_pkg::IDX_W'(bpa_pkg::PAGES - 1);
		stat.page       = page_q;
	end

	a_take_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bpa_pkg::CMD_TAKE |-> cnt_q[ord_q] != '0)
		else $error("take from empty order");
	a_split_above: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bpa_pkg::CMD_SPLIT |-> ord_q > req_q)
		else $error("split below request");
	a_merge_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bpa_pkg::CMD_MERGE |-> {1'b0, ord_q} + 1'b1 <
			(bpa_pkg::ORD_W + 1)'(bpa_pkg::ORDERS))
		else $error("merge past top order");

endmodule

@@ design/bpa_ctrl.sv @@
// ---------------------------------------------------------------------------
// bpa_ctrl - allocator sequencer
// Clearing pass, allocate scan and split, free check and merge walk.
// ---------------------------------------------------------------------------
module bpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	input  logic              out_free,
	input  bpa_pkg::dp_stat_t stat,
	output logic              in_ready,
	output bpa_pkg::dp_cmd_t  cmd,
	output bpa_pkg::resp_t    resp
);

	bpa_pkg::state_t     state_q, state_d;
	bpa_pkg::stat_code_t code_q, code_d;
	logic                use_q, use_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::S_CLEAR;
			code_q  <= bpa_pkg::STAT_OK;
			use_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			use_q   <= use_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		code_d     = code_q;
		use_d      = use_q;
		cmd.op     = bpa_pkg::CMD_NONE;
		in_ready   = 1'b0;
		resp.valid = 1'b0;
		resp.code  = code_q;
		resp.use_page = use_q;
		case (state_q)
			bpa_pkg::S_CLEAR: begin
				cmd.op = bpa_pkg::CMD_CLEAR;
				if (stat.clr_done)
					state_d = bpa_pkg::S_IDLE;
			end
			bpa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					use_d = 1'b0;
					if (opcode == bpa_pkg::OP_ALLOC) begin
						if (stat.alloc_ok) begin
							cmd.op  = bpa_pkg::CMD_LOAD;
							state_d = bpa_pkg::S_SCAN_RD;
						end else begin
							code_d  = bpa_pkg::STAT_NOFREE;
							state_d = bpa_pkg::S_RESP;
						end
					end else begin
						if (stat.req_ok) begin
							cmd.op  = bpa_pkg::CMD_LOAD;
							state_d = bpa_pkg::S_FREE_RD;
						end else begin
							code_d  = bpa_pkg::STAT_BADFREE;
							state_d = bpa_pkg::S_RESP;
						end
					end
				end
			end
			bpa_pkg::S_SCAN_RD: begin
				cmd.op  = bpa_pkg::CMD_RD_IDX;
				state_d = bpa_pkg::S_SCAN_CHK;
			end
			bpa_pkg::S_SCAN_CHK: begin
				if (stat.hit_free) begin
					cmd.op  = bpa_pkg::CMD_TAKE;
					state_d = bpa_pkg::S_SPLIT;
				end else begin
					cmd.op  = bpa_pkg::CMD_SCAN_NEXT;
					state_d = bpa_pkg::S_SCAN_RD;
				end
			end
			bpa_pkg::S_SPLIT: begin
				if (stat.split_more) begin
					cmd.op = bpa_pkg::CMD_SPLIT;
				end else begin
					cmd.op  = bpa_pkg::CMD_MARK_BUSY;
					code_d  = bpa_pkg::STAT_OK;
					use_d   = 1'b1;
					state_d = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_FREE_RD: begin
				cmd.op  = bpa_pkg::CMD_RD_PAGE;
				state_d = bpa_pkg::S_FREE_CHK;
			end
			bpa_pkg::S_FREE_CHK: begin
				if (stat.hit_busy) begin
					cmd.op  = bpa_pkg::CMD_CLR_PAGE;
					state_d = bpa_pkg::S_MERGE_TRY;
				end else begin
					code_d  = bpa_pkg::STAT_BADFREE;
					state_d = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_MERGE_TRY: begin
				if (stat.merge_try) begin
					cmd.op  = bpa_pkg::CMD_RD_BUDDY;
					state_d = bpa_pkg::S_MERGE_CHK;
				end else begin
					cmd.op  = bpa_pkg::CMD_PUT_FREE;
					code_d  = bpa_pkg::STAT_OK;
					state_d = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_MERGE_CHK: begin
				if (stat.hit_free) begin
					cmd.op  = bpa_pkg::CMD_MERGE;
					state_d = bpa_pkg::S_MERGE_TRY;
				end else begin
					cmd.op  = bpa_pkg::CMD_PUT_FREE;
					code_d  = bpa_pkg::STAT_OK;
					state_d = bpa_pkg::S_RESP;
				end
			end
			bpa_pkg::S_RESP: begin
				if (out_free) begin
					resp.valid = 1'b1;
					state_d    = bpa_pkg::S_IDLE;
				end
			end
			default: state_d = bpa_pkg::S_IDLE;
		endcase
	end

endmodule

@@ design/buddy_page_allocator.sv @@
// ---------------------------------------------------------------------------
// buddy_page_allocator - buddy allocator over 1024 pages, orders 0 to 9
// Top level: request/response streams, sequencer, datapath, output register.
// ---------------------------------------------------------------------------
// Usage:
//  - s_* carries one request: allocate a block of block_order, or free the
//    block of block_order that starts at page_index. m_* carries exactly one
//    response per request: status and result_page.
//  - Requests are worked one at a time; s_tready is high only while the
//    sequencer is idle.
//  - Sequence: a request rejected on its fields answers with no table
//    access, a free of a block that is not a busy head after reading it.
//    An allocation probes table slots at the chosen order (stride 2^order,
//    so at most 1024 >> order) and then splits down to the request. A free
//    clears the head and probes buddies (at most 9), merging upward, then
//    writes the merged head. The block table is single-port, one access a
//    cycle.
//  - Reset: the table is rebuilt by a clearing pass over all 1024 entries,
//    one entry a cycle; no request is taken until it ends.
//  - Stall: the response sits in the output register until m_tready; the
//    sequencer then holds its finished response and takes no new request.
module buddy_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [0] opcode, [4:1] block_order, [14:5] page_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [11:2] result_page
);

	bpa_pkg::dp_cmd_t  cmd;
	bpa_pkg::dp_stat_t stat;
	bpa_pkg::resp_t    resp;

	logic                        opcode;
	logic [bpa_pkg::ORD_W-1:0]   block_order;
	logic [bpa_pkg::PAGE_W-1:0]  page_index;
	logic                        m_tvalid_q;
	logic [1:0]                  status_q;
	logic [bpa_pkg::PAGE_W-1:0]  page_out_q;

	assign opcode      = s_tdata[0];
	assign block_order = s_tdata[4:1];
	assign page_index  = s_tdata[14:5];

	bpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.opcode   (opcode),
		.out_free (!m_tvalid_q || m_tready),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd),
		.resp     (resp)
	);

	bpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.block_order (block_order),
		.page_index  (page_index),
		.stat        (stat)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (resp.valid)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (resp.valid) begin
			status_q   <= resp.code;
			page_out_q <= resp.use_page ? stat.page : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, page_out_q, status_q};

endmodule

@@ tb/buddy_page_allocator_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// buddy_page_allocator_tb - self-checking bench for the buddy page allocator
// A local copy of the block table and per-order free counts predicts the
// status and page of every request. Responses are checked in order, with
// random gaps on both streams, a long response stall and a full drain.
// ---------------------------------------------------------------------------
module buddy_page_allocator_tb;

	localparam int TIMEOUT_CYCLES = 20000;

	typedef struct packed {
		logic [1:0]                 status;
		logic [bpa_pkg::PAGE_W-1:0] page;
	} alloc_resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	// predictor state
	logic [bpa_pkg::ENT_W-1:0] pg_table [bpa_pkg::PAGES];
	int               free_cnt [bpa_pkg::ORDERS];
	alloc_resp_t      pending_resp [$];
	int               busy_pages [$];   // heads currently allocated
	int               busy_orders [$];
	int               errors = 0;
	int               resp_seen = 0;
	int               idle_cycles = 0;
	bit               hold_off = 0;

	buddy_page_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic table_reset();
		for (int i = 0; i < bpa_pkg::PAGES; i++) begin
			if (i < bpa_pkg::FULL)
				pg_table[i] = (i % bpa_pkg::TOP_SZ == 0)
					? (bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(bpa_pkg::ORDERS - 1)) : '0;
			else
				pg_table[i] = bpa_pkg::ENT_HEAD;
		end
		foreach (free_cnt[o]) free_cnt[o] = 0;
		free_cnt[bpa_pkg::ORDERS-1] = bpa_pkg::FULL / bpa_pkg::TOP_SZ;
		free_cnt[0] += bpa_pkg::PAGES - bpa_pkg::FULL;
	endtask

	// allocation: lowest-address head at the smallest order that has one
	function automatic alloc_resp_t predict_alloc(int req);
		alloc_resp_t r;
		int p;
		r.status = bpa_pkg::STAT_NOFREE;
		r.page = '0;
		if (req >= bpa_pkg::ORDERS) return r;
		for (int o = req; o < bpa_pkg::ORDERS; o++) begin
			if (free_cnt[o] == 0) continue;
			p = -1;
			for (int i = 0; i < bpa_pkg::PAGES; i++)
				if (pg_table[i] == (bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(o))) begin
					p = i;
					break;
				end
			if (p < 0) continue;
			free_cnt[o]--;
			for (int k = o; k > req; ) begin
				k--;
				pg_table[p] = bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(k);
				free_cnt[k]++;
				p += 1 << k;
			end
			pg_table[p] = bpa_pkg::ENT_HEAD | bpa_pkg::ENT_BUSY | bpa_pkg::ENT_W'(req);
			r.status = bpa_pkg::STAT_OK;
			r.page = bpa_pkg::PAGE_W'(p);
			return r;
		end
		return r;
	endfunction

	// free: reject unless a busy head of that order, then merge upward
	function automatic alloc_resp_t predict_free(int o, int p);
		alloc_resp_t r;
		int b;
		r.status = bpa_pkg::STAT_BADFREE;
		r.page = '0;
		if (o >= bpa_pkg::ORDERS || p >= bpa_pkg::PAGES) return r;
		if (pg_table[p] != (bpa_pkg::ENT_HEAD | bpa_pkg::ENT_BUSY | bpa_pkg::ENT_W'(o)))
			return r;
		pg_table[p] = '0;
		while (o + 1 < bpa_pkg::ORDERS) begin
			b = p ^ (1 << o);
			if (b >= bpa_pkg::PAGES || pg_table[b] != (bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(o)))
				break;
			pg_table[b] = '0;
			free_cnt[o]--;
			p &= ~(1 << o);
			o++;
		end
		pg_table[p] = bpa_pkg::ENT_HEAD | bpa_pkg::ENT_W'(o);
		free_cnt[o]++;
		r.status = bpa_pkg::STAT_OK;
		return r;
	endfunction

	// send one request after a random gap, predict on acceptance;
	// tvalid stays up between back-to-back requests
	task automatic send_request(logic op, logic [3:0] ord, logic [9:0] pg);
		alloc_resp_t r;
		int gap;
		gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, pg, ord, op};
		do @(posedge clk); while (!s_tready);
		if (op == bpa_pkg::OP_ALLOC) begin
			r = predict_alloc(ord);
			if (r.status == bpa_pkg::STAT_OK) begin
				busy_pages.push_back(r.page);
				busy_orders.push_back(ord);
			end
		end else begin
			r = predict_free(ord, pg);
			if (r.status == bpa_pkg::STAT_OK)
				foreach (busy_pages[i])
					if (busy_pages[i] == pg) begin
						busy_pages.delete(i);
						busy_orders.delete(i);
						break;
					end
		end
		pending_resp.push_back(r);
	endtask

	task automatic alloc_req(int ord);
		send_request(bpa_pkg::OP_ALLOC, 4'(ord), 10'($urandom));
	endtask

	task automatic free_req(int ord, int pg);
		send_request(bpa_pkg::OP_FREE, 4'(ord), 10'(pg));
	endtask

	// free a random outstanding block
	task automatic free_some();
		int i;
		i = $urandom_range(0, busy_pages.size() - 1);
		free_req(busy_orders[i], busy_pages[i]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	// extremes, bad orders, bad frees, order mismatch, full merge
	task automatic test_directed();
		alloc_req(0);                  // splits a top block all the way down, page 511
		alloc_req(bpa_pkg::ORDERS - 1);
		alloc_req(bpa_pkg::ORDERS - 1); // nothing left at top order
		alloc_req(15);                 // order too large
		alloc_req(bpa_pkg::ORDERS);
		free_req(15, 0);               // free order too large
		free_req(0, 1023);             // not a busy head
		free_req(1, 511);              // order mismatch
		free_req(0, 5);
		free_req(0, 511);              // merges back to the top order
		free_req(0, 511);              // double free
		alloc_req(3);
		alloc_req(3);
		free_req(3, 496);
		free_req(3, 504);
		while (busy_pages.size() != 0) free_some();
		drain();
	endtask

	// mixed allocate/free with random content, some noise
	task automatic test_random(int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				alloc_req(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
				                                      : $urandom_range(0, 4));
			else if (sel < 88 && busy_pages.size() != 0)
				free_some();
			else
				send_request(bpa_pkg::OP_FREE, 4'($urandom), 10'($urandom));
		end
	endtask

	// response side stalls for a long stretch while requests keep coming
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			test_random(30);
		join
		drain();
	endtask

	task automatic test_release_all();
		while (busy_pages.size() != 0) free_some();
		drain();
	endtask

	// response ready with random stalls
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (m_tready && m_tvalid) begin
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
				if (stall != 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		alloc_resp_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			resp_seen++;
			if (pending_resp.size() == 0) begin
				$error("unexpected response %h", m_tdata);
				errors++;
			end else begin
				exp_r = pending_resp.pop_front();
				if (m_tdata[1:0] !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[11:2] !== exp_r.page) begin
					$error("result_page: expected %0d, actual %0d", exp_r.page,
					       m_tdata[11:2]);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any handshake (clearing pass included)
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > TIMEOUT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		table_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(700);
		test_backpressure();
		test_random(750);
		test_release_all();
		if (errors == 0 && pending_resp.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
